### hw/rtl/rspt_pkg.sv
// rspt_pkg: types and constants for the radio second pulse phase tracker
// word layouts of both channels, mode and register codes, reset values
// no dependencies
package rspt_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic [22:0] edge_timer_count;
    logic        timer_running;
    logic [16:0] second_value;
  } in_item_t;

  typedef struct packed {
    logic        pulse_valid;
    logic [31:0] pulse_start_ms;
    logic [31:0] pulse_width_ms;
    logic        reload_write;
    logic [22:0] reload_value;
    logic        seconds_known;
    logic [16:0] seconds_value;
  } out_item_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 23;

  localparam logic [2:0] MODE_RISE = 3'd0;
  localparam logic [2:0] MODE_FALL = 3'd1;
  localparam logic [2:0] MODE_TICK = 3'd2;
  localparam logic [2:0] MODE_LOAD = 3'd3;
  localparam logic [2:0] MODE_POLL = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_MIN_PULSE_MS     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NOMINAL_PERIOD   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNSYNC_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ADAPT_THRESHOLD  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_UNSYNC_COUNT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SECONDS_WRAP     = 3'd6;

  localparam logic [9:0]  RST_MIN_PULSE_MS     = 10'd50;
  localparam logic [22:0] RST_NOMINAL_PERIOD   = 23'd5000000;
  localparam logic [22:0] RST_HALF_PERIOD      = 23'd2500000;
  localparam logic [22:0] RST_UNSYNC_THRESHOLD = 23'd250000;
  localparam logic [22:0] RST_ADAPT_THRESHOLD  = 23'd5000;
  localparam logic [7:0]  RST_MAX_UNSYNC_COUNT = 8'd5;
  localparam logic [16:0] RST_SECONDS_WRAP     = 17'd86400;

  localparam logic [22:0] PERIOD_MAX     = 23'h7FFFFF;
  localparam logic [7:0]  UNSYNC_SAT     = 8'd255;
  localparam int unsigned SEC_W          = 17;

  // background reduction of the seconds counter modulo seconds_wrap
  typedef enum logic [1:0] {
    RS_READY,
    RS_LOAD,
    RS_SHIFT
  } red_state_t;

endpackage

### hw/rtl/radio_second_pulse_phase_tracker_top.sv
// radio_second_pulse_phase_tracker_top: second timer phase lock to radio pulses
// uses rspt_pkg for word types, mode and register codes
// single module: event datapath, seconds reducer, two-entry result buffer
//
// channels: in (valid/ready, one event word), out (valid/ready, one result
// word per event), cfg (valid/ready, index and data, always ready).
// every accepted event gives exactly one result word, registered into the
// output or skid register. one event is taken per cycle unless stalled.
// the result side has an output register plus a skid register: one more
// event is taken while a result waits, then in_ready drops until out drains.
// the seconds counter keeps a copy reduced modulo seconds_wrap, worked out
// by a one-bit-a-step remainder unit. after a write to seconds_wrap, or a
// tick that loads a second at or above seconds_wrap, that unit runs one load
// step and 17 shift steps (only the load step when the wrap is zero), and
// in_ready stays low meanwhile.
// reset (rst, synchronous) restores all registers to their reset values,
// clears all marks and pending flags, empties the result buffer and leaves
// the seconds counter unknown; in_ready is high in the cycle after reset.
module radio_second_pulse_phase_tracker_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rspt_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rspt_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rspt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rspt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rspt_pkg::*;

  // configuration
  logic [9:0]  min_pulse_ms;
  logic [22:0] nominal_period;
  logic [22:0] half_period;
  logic [22:0] unsync_threshold;
  logic [22:0] adapt_threshold;
  logic [7:0]  max_unsync_count;
  logic [16:0] seconds_wrap;
  logic        cfg_write;
  logic        wrap_write;

  // event state
  logic [31:0] rise_time, rise_time_next;
  logic [31:0] fall_time, fall_time_next;
  logic        rise_pending, rise_pending_next;
  logic        fall_pending, fall_pending_next;
  logic [22:0] edge_capture, edge_capture_next;
  logic        edge_pending, edge_pending_next;
  logic [7:0]  unsync_count, unsync_count_next;
  logic [22:0] last_period, last_period_next;
  logic [16:0] seconds_count, seconds_count_next;
  logic        seconds_valid, seconds_valid_next;
  logic [16:0] staged_second, staged_second_next;
  logic        staged_second_valid, staged_second_valid_next;
  logic [16:0] seconds_red, seconds_red_next;

  // tick arithmetic
  logic        late;
  logic [22:0] diff;
  logic [22:0] diff_half;
  logic        unsync_step;
  logic [7:0]  unsync_inc;
  logic        adapt;
  logic [22:0] period_short;
  logic [23:0] period_sum;
  logic [22:0] period_long;
  logic [16:0] red_plus;
  logic [16:0] seconds_inc;
  logic [31:0] width;
  logic        red_restart;

  out_item_t   result;
  logic        accept;

  // remainder unit
  red_state_t  red_state, red_state_next;
  logic        red_ready;
  logic        red_load;
  logic        red_step;
  logic [16:0] div_rem;
  logic [16:0] div_bits;
  logic [4:0]  div_cnt;
  logic [17:0] div_trial;
  logic [16:0] div_rem_next;

  // result buffer
  logic        skid_valid;
  out_item_t   skid_data;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign wrap_write = cfg_write && (cfg_index == REG_SECONDS_WRAP);
  assign in_ready   = red_ready && !skid_valid;
  assign accept     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse_ms     <= RST_MIN_PULSE_MS;
      nominal_period   <= RST_NOMINAL_PERIOD;
      half_period      <= RST_HALF_PERIOD;
      unsync_threshold <= RST_UNSYNC_THRESHOLD;
      adapt_threshold  <= RST_ADAPT_THRESHOLD;
      max_unsync_count <= RST_MAX_UNSYNC_COUNT;
      seconds_wrap     <= RST_SECONDS_WRAP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_PULSE_MS:     min_pulse_ms     <= cfg_data[9:0];
        REG_NOMINAL_PERIOD:   nominal_period   <= cfg_data;
        REG_HALF_PERIOD:      half_period      <= cfg_data;
        REG_UNSYNC_THRESHOLD: unsync_threshold <= cfg_data;
        REG_ADAPT_THRESHOLD:  adapt_threshold  <= cfg_data;
        REG_MAX_UNSYNC_COUNT: max_unsync_count <= cfg_data[7:0];
        REG_SECONDS_WRAP:     seconds_wrap     <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // phase error vs. the last rising-edge capture, periods, next second, width
  always_comb begin
    late         = edge_capture < half_period;
    if (late) begin
      diff = edge_capture;
    end else if (last_period > edge_capture) begin
      diff = last_period - edge_capture;
    end else begin
      diff = '0;
    end
    diff_half    = diff >> 1;
    unsync_step  = (diff > unsync_threshold) && (unsync_count != UNSYNC_SAT);
    unsync_inc   = unsync_count + {7'd0, unsync_step};
    adapt        = edge_pending && (diff > adapt_threshold) &&
                   ((diff <= unsync_threshold) || (unsync_inc >= max_unsync_count));
    period_short = (nominal_period > diff_half) ? nominal_period - diff_half : '0;
    period_sum   = {1'b0, nominal_period} + {1'b0, diff_half};
    period_long  = period_sum[23] ? PERIOD_MAX : period_sum[22:0];
    // the reduced copy is below the wrap, so one compare finishes the modulo
    red_plus     = seconds_red + 17'd1;
    if (seconds_wrap == '0) begin
      seconds_inc = seconds_count + 17'd1;
    end else if (red_plus == seconds_wrap) begin
      seconds_inc = '0;
    end else begin
      seconds_inc = red_plus;
    end
    width        = fall_time - rise_time;
  end

  always_comb begin
    rise_time_next           = rise_time;
    fall_time_next           = fall_time;
    rise_pending_next        = rise_pending;
    fall_pending_next        = fall_pending;
    edge_capture_next        = edge_capture;
    edge_pending_next        = edge_pending;
    unsync_count_next        = unsync_count;
    last_period_next         = last_period;
    seconds_count_next       = seconds_count;
    seconds_valid_next       = seconds_valid;
    staged_second_next       = staged_second;
    staged_second_valid_next = staged_second_valid;
    seconds_red_next         = seconds_red;
    red_restart              = 1'b0;
    result                   = '0;
    case (in_data.mode)
      MODE_RISE: begin
        rise_time_next    = in_data.now_ms;
        fall_pending_next = 1'b0;
        rise_pending_next = 1'b1;
        if (in_data.timer_running) begin
          edge_capture_next = in_data.edge_timer_count;
          edge_pending_next = 1'b1;
        end
      end
      MODE_FALL: begin
        fall_time_next    = in_data.now_ms;
        fall_pending_next = 1'b1;
      end
      MODE_TICK: begin
        edge_pending_next = 1'b0;
        if (adapt) begin
          last_period_next    = late ? period_short : period_long;
          unsync_count_next   = '0;
          result.reload_write = 1'b1;
          result.reload_value = last_period_next;
        end else begin
          last_period_next  = nominal_period;
          unsync_count_next = unsync_inc;
          if (last_period != nominal_period) begin
            result.reload_write = 1'b1;
            result.reload_value = nominal_period;
          end
        end
        if (staged_second_valid) begin
          seconds_count_next       = staged_second;
          seconds_red_next         = staged_second;
          seconds_valid_next       = 1'b1;
          staged_second_valid_next = 1'b0;
          // a loaded second at or above a nonzero wrap needs a full remainder pass
          red_restart = (seconds_wrap != '0) && (staged_second >= seconds_wrap);
        end else if (seconds_valid) begin
          seconds_count_next = seconds_inc;
          seconds_red_next   = seconds_inc;
        end
      end
      MODE_LOAD: begin
        staged_second_next       = in_data.second_value;
        staged_second_valid_next = 1'b1;
      end
      MODE_POLL: begin
        if (rise_pending && fall_pending) begin
          rise_pending_next = 1'b0;
          fall_pending_next = 1'b0;
          if (width >= {22'd0, min_pulse_ms}) begin
            result.pulse_valid    = 1'b1;
            result.pulse_start_ms = rise_time;
            result.pulse_width_ms = width;
          end
        end
      end
      default: ;
    endcase
    result.seconds_known = seconds_valid_next;
    result.seconds_value = seconds_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_time           <= '0;
      fall_time           <= '0;
      rise_pending        <= 1'b0;
      fall_pending        <= 1'b0;
      edge_capture        <= '0;
      edge_pending        <= 1'b0;
      unsync_count        <= '0;
      last_period         <= RST_NOMINAL_PERIOD;
      seconds_count       <= '0;
      seconds_valid       <= 1'b0;
      staged_second       <= '0;
      staged_second_valid <= 1'b0;
      seconds_red         <= '0;
    end else if (accept) begin
      rise_time           <= rise_time_next;
      fall_time           <= fall_time_next;
      rise_pending        <= rise_pending_next;
      fall_pending        <= fall_pending_next;
      edge_capture        <= edge_capture_next;
      edge_pending        <= edge_pending_next;
      unsync_count        <= unsync_count_next;
      last_period         <= last_period_next;
      seconds_count       <= seconds_count_next;
      seconds_valid       <= seconds_valid_next;
      staged_second       <= staged_second_next;
      staged_second_valid <= staged_second_valid_next;
      seconds_red         <= seconds_red_next;
    end else if (red_step && (div_cnt == '0)) begin
      seconds_red <= div_rem_next;
    end
  end

  // remainder unit: seconds_count mod seconds_wrap, one dividend bit a cycle
  always_comb begin
    red_state_next = red_state;
    unique case (red_state)
      RS_READY: if (red_restart && accept) red_state_next = RS_LOAD;
      RS_LOAD:  red_state_next = (seconds_wrap == '0) ? RS_READY : RS_SHIFT;
      RS_SHIFT: if (div_cnt == '0) red_state_next = RS_READY;
      default:  red_state_next = RS_READY;
    endcase
    // a new wrap value restarts the pass from wherever it stands
    if (wrap_write) red_state_next = RS_LOAD;
  end

  always_comb begin
    red_ready = (red_state == RS_READY);
    red_load  = (red_state == RS_LOAD);
    red_step  = (red_state == RS_SHIFT);
  end

  always_comb begin
    div_trial = {div_rem, div_bits[SEC_W-1]};
    if (div_trial >= {1'b0, seconds_wrap}) begin
      div_rem_next = 17'(div_trial - {1'b0, seconds_wrap});
    end else begin
      div_rem_next = div_trial[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_state <= RS_READY;
    end else begin
      red_state <= red_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (red_load) begin
      div_rem  <= '0;
      div_bits <= seconds_count;
      div_cnt  <= 5'(SEC_W - 1);
    end else if (red_step) begin
      div_rem  <= div_rem_next;
      div_bits <= div_bits << 1;
      div_cnt  <= div_cnt - 5'd1;
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held while output register empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid word filled without an output stall");

  a_red_below_wrap: assert property (@(posedge clk) disable iff (rst)
    (red_ready && (seconds_wrap != '0)) |-> (seconds_red < seconds_wrap))
    else $error("reduced seconds copy not below the wrap");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for radio_second_pulse_phase_tracker_top
// directed table, then pulse/tick sequences under several register settings
// needs rspt_pkg and the top module, nothing else
module tb;
  import rspt_pkg::*;

  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 64;
  localparam int SAT_TICKS     = 260;

  typedef struct {
    in_item_t  ev;
    bit        typed;
    out_item_t want;
  } drill_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  radio_second_pulse_phase_tracker_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies
  logic [9:0]  cf_min_pulse;
  logic [22:0] cf_nominal, cf_half, cf_unsync, cf_adapt;
  logic [7:0]  cf_max_unsync;
  logic [16:0] cf_wrap;

  // tracker state copies
  logic [31:0] rise_ms, fall_ms;
  logic        rise_marked, fall_marked;
  logic [22:0] capture_count;
  logic        capture_fresh;
  logic [7:0]  unsync_ticks;
  logic [22:0] period_now;
  logic [16:0] sod_count, sod_next;
  logic        sod_known, sod_next_set;

  out_item_t  awaited_words[$];
  drill_row_t drill[$];
  out_item_t  head_word;
  int error_count = 0;
  int events_sent = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req;
  bit hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t mk_ev(input logic [2:0] mode, input logic [31:0] now,
                                     input logic [22:0] cnt, input logic running,
                                     input logic [16:0] sec);
    in_item_t e;
    e.mode = mode;
    e.now_ms = now;
    e.edge_timer_count = cnt;
    e.timer_running = running;
    e.second_value = sec;
    return e;
  endfunction

  function automatic in_item_t noisy_ev(input logic [2:0] mode);
    return mk_ev(mode, $urandom, 23'($urandom), 1'($urandom), 17'($urandom));
  endfunction

  function automatic out_item_t mk_res(input logic pv, input logic [31:0] start,
                                       input logic [31:0] width, input logic rw,
                                       input logic [22:0] rv, input logic sk,
                                       input logic [16:0] sv);
    out_item_t r;
    r.pulse_valid = pv;
    r.pulse_start_ms = start;
    r.pulse_width_ms = width;
    r.reload_write = rw;
    r.reload_value = rv;
    r.seconds_known = sk;
    r.seconds_value = sv;
    return r;
  endfunction

  // next result word and state update for one event
  function automatic out_item_t track_event(input in_item_t ev);
    out_item_t r;
    logic late, wr;
    logic [31:0] err, nxt, half_err, sec_inc, width;
    r = '0;
    case (ev.mode)
      MODE_RISE: begin
        rise_ms = ev.now_ms;
        fall_marked = 1'b0;
        rise_marked = 1'b1;
        if (ev.timer_running) begin
          capture_count = ev.edge_timer_count;
          capture_fresh = 1'b1;
        end
      end
      MODE_FALL: begin
        fall_ms = ev.now_ms;
        fall_marked = 1'b1;
      end
      MODE_TICK: begin
        late = capture_count < cf_half;
        if (late) err = 32'(capture_count);
        else err = 32'((period_now > capture_count) ? period_now - capture_count : '0);
        if (err > cf_unsync && unsync_ticks != UNSYNC_SAT) unsync_ticks++;
        nxt = 32'(cf_nominal);
        wr = 1'b0;
        if (capture_fresh && err > cf_adapt &&
            (err <= cf_unsync || unsync_ticks >= cf_max_unsync)) begin
          half_err = err >> 1;
          if (late) begin
            nxt = (cf_nominal > half_err) ? cf_nominal - half_err : '0;
          end else begin
            nxt = cf_nominal + half_err;
            if (nxt > PERIOD_MAX) nxt = 32'(PERIOD_MAX);
          end
          unsync_ticks = '0;
          wr = 1'b1;
        end else if (period_now != cf_nominal) begin
          wr = 1'b1;
        end
        capture_fresh = 1'b0;
        period_now = nxt[22:0];
        if (wr) begin
          r.reload_write = 1'b1;
          r.reload_value = nxt[22:0];
        end
        if (sod_known) begin
          sec_inc = sod_count + 1;
          // a zero modulus leaves the plain 17-bit wrap
          if (cf_wrap == '0) sod_count = sec_inc[16:0];
          else sod_count = 17'(sec_inc % cf_wrap);
        end
        if (sod_next_set) begin
          sod_count = sod_next;
          sod_known = 1'b1;
          sod_next_set = 1'b0;
        end
      end
      MODE_LOAD: begin
        sod_next = ev.second_value;
        sod_next_set = 1'b1;
      end
      MODE_POLL: begin
        if (rise_marked && fall_marked) begin
          width = fall_ms - rise_ms;
          rise_marked = 1'b0;
          fall_marked = 1'b0;
          if (width >= cf_min_pulse) begin
            r.pulse_valid = 1'b1;
            r.pulse_start_ms = rise_ms;
            r.pulse_width_ms = width;
          end
        end
      end
      default: begin
      end
    endcase
    r.seconds_known = sod_known;
    r.seconds_value = sod_count;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    error_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic offer_event(input in_item_t ev, input bit typed = 1'b0,
                             input out_item_t want = '0);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (!in_ready);
    predicted = track_event(ev);
    awaited_words.push_back(typed ? want : predicted);
    if (ev.mode < MODE_SPARE_FIRST) events_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [22:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_PULSE_MS:     cf_min_pulse = val[9:0];
      REG_NOMINAL_PERIOD:   cf_nominal = val;
      REG_HALF_PERIOD:      cf_half = val;
      REG_UNSYNC_THRESHOLD: cf_unsync = val;
      REG_ADAPT_THRESHOLD:  cf_adapt = val;
      REG_MAX_UNSYNC_COUNT: cf_max_unsync = val[7:0];
      REG_SECONDS_WRAP:     cf_wrap = val[16:0];
      default: begin
      end
    endcase
  endtask

  task automatic program_regs(input logic [9:0] min_pulse, input logic [22:0] nominal,
                              input logic [22:0] half, input logic [22:0] unsync,
                              input logic [22:0] adapt, input logic [7:0] max_unsync,
                              input logic [16:0] wrap);
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    // the seconds reducer may still be busy after the last word
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_MIN_PULSE_MS, 23'(min_pulse));
    write_reg(REG_NOMINAL_PERIOD, nominal);
    write_reg(REG_HALF_PERIOD, half);
    write_reg(REG_UNSYNC_THRESHOLD, unsync);
    write_reg(REG_ADAPT_THRESHOLD, adapt);
    write_reg(REG_MAX_UNSYNC_COUNT, 23'(max_unsync));
    write_reg(REG_SECONDS_WRAP, 23'(wrap));
    cfg_valid <= 1'b0;
  endtask

  function automatic void pick_idle(input int k);
    case (k % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 65; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 65; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endfunction

  // one received second: rise, an optional poll, fall, an optional poll, maybe a load, then the tick
  task automatic run_second();
    logic [31:0] t0, width, err;
    logic [22:0] cnt;
    logic [16:0] sec;
    t0 = $urandom;
    case ($urandom_range(2))
      0: err = $urandom_range(2 * cf_adapt + 2);
      1: err = $urandom_range(2 * cf_unsync + 2);
      default: err = $urandom_range(PERIOD_MAX);
    endcase
    if (err > PERIOD_MAX) err = 32'(PERIOD_MAX);
    if ($urandom_range(1) == 0) cnt = err[22:0];
    else if (period_now >= err) cnt = period_now - err[22:0];
    else cnt = 23'($urandom);
    case ($urandom_range(3))
      0: width = cf_min_pulse + $urandom_range(4) - 2;
      1: width = $urandom_range(1100);
      2: width = $urandom_range(250, 50);
      default: width = $urandom;
    endcase
    offer_event(mk_ev(MODE_RISE, t0, cnt, $urandom_range(9) != 0, 17'($urandom)));
    if ($urandom_range(9) == 0) offer_event(noisy_ev(MODE_POLL));
    offer_event(mk_ev(MODE_FALL, t0 + width, 23'($urandom), 1'($urandom), 17'($urandom)));
    if ($urandom_range(9) != 0) offer_event(noisy_ev(MODE_POLL));
    if ($urandom_range(3) == 0) begin
      if (cf_wrap != '0 && $urandom_range(4) != 0) sec = 17'($urandom_range(cf_wrap - 1));
      else sec = 17'($urandom);
      offer_event(mk_ev(MODE_LOAD, $urandom, 23'($urandom), 1'($urandom), sec));
    end
    offer_event(noisy_ev(MODE_TICK));
  endtask

  task automatic run_traffic(input int target);
    int first;
    first = events_sent;
    while (events_sent - first < target) begin
      if ($urandom_range(99) < 70) run_second();
      else offer_event(noisy_ev(3'($urandom_range(MODE_SPARE_LAST))));
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        repeat (LONG_HOLD) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_words.size() == 0) begin
        note_mismatch("result word with nothing expected");
      end else begin
        head_word = awaited_words.pop_front();
        check_field("pulse_valid", 32'(out_data.pulse_valid),
                    32'(head_word.pulse_valid));
        check_field("pulse_start_ms", out_data.pulse_start_ms, head_word.pulse_start_ms);
        check_field("pulse_width_ms", out_data.pulse_width_ms, head_word.pulse_width_ms);
        check_field("reload_write", 32'(out_data.reload_write),
                    32'(head_word.reload_write));
        check_field("reload_value", 32'(out_data.reload_value),
                    32'(head_word.reload_value));
        check_field("seconds_known", 32'(out_data.seconds_known),
                    32'(head_word.seconds_known));
        check_field("seconds_value", 32'(out_data.seconds_value),
                    32'(head_word.seconds_value));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [22:0] nominal, unsync;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    hold_req <= 1'b0;

    cf_min_pulse = RST_MIN_PULSE_MS;
    cf_nominal = RST_NOMINAL_PERIOD;
    cf_half = RST_HALF_PERIOD;
    cf_unsync = RST_UNSYNC_THRESHOLD;
    cf_adapt = RST_ADAPT_THRESHOLD;
    cf_max_unsync = RST_MAX_UNSYNC_COUNT;
    cf_wrap = RST_SECONDS_WRAP;
    rise_ms = '0;
    fall_ms = '0;
    rise_marked = 1'b0;
    fall_marked = 1'b0;
    capture_count = '0;
    capture_fresh = 1'b0;
    unsync_ticks = '0;
    period_now = RST_NOMINAL_PERIOD;
    sod_count = '0;
    sod_known = 1'b0;
    sod_next = '0;
    sod_next_set = 1'b0;

    // reset values; typed rows are plain from the register defaults
    drill.push_back('{mk_ev(MODE_POLL, '0, '0, 1'b0, '0), 1'b1, '0});
    drill.push_back('{mk_ev(MODE_SPARE_LAST, 32'hFFFF_FFFF, PERIOD_MAX, 1'b1, 17'h1FFFF),
                      1'b1, '0});
    drill.push_back('{mk_ev(MODE_TICK, '0, '0, 1'b0, '0), 1'b1, '0});
    // pulse straddling the timestamp wrap
    drill.push_back('{mk_ev(MODE_RISE, 32'hFFFF_FFF0, PERIOD_MAX, 1'b1, '0), 1'b1, '0});
    drill.push_back('{mk_ev(MODE_FALL, 32'h40, '0, 1'b0, '0), 1'b1, '0});
    drill.push_back('{mk_ev(MODE_POLL, '0, '0, 1'b0, '0), 1'b1,
                      mk_res(1'b1, 32'hFFFF_FFF0, 32'd80, 1'b0, '0, 1'b0, '0)});
    drill.push_back('{mk_ev(MODE_POLL, '0, '0, 1'b0, '0), 1'b1, '0});
    // second above the wrap, then a tick with a capture past the period
    drill.push_back('{mk_ev(MODE_LOAD, '0, '0, 1'b0, 17'h1FFFF), 1'b1, '0});
    drill.push_back('{mk_ev(MODE_TICK, '0, '0, 1'b0, '0), 1'b1,
                      mk_res(1'b0, '0, '0, 1'b0, '0, 1'b1, 17'h1FFFF)});
    drill.push_back('{mk_ev(MODE_TICK, '0, '0, 1'b0, '0), 1'b0, '0});
    // short pulse clears the marks
    drill.push_back('{mk_ev(MODE_RISE, 32'd1000, '0, 1'b0, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_FALL, 32'd1049, '0, 1'b0, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_POLL, '0, '0, 1'b0, '0), 1'b0, '0});
    // fall alone is kept across a poll
    drill.push_back('{mk_ev(MODE_FALL, 32'd1100, '0, 1'b0, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_POLL, '0, '0, 1'b0, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_RISE, 32'd2000, 23'd4990000, 1'b1, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_FALL, 32'd2100, '0, 1'b0, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_POLL, '0, '0, 1'b0, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_TICK, '0, '0, 1'b0, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_TICK, '0, '0, 1'b0, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_RISE, 32'd3000, 23'd20000, 1'b1, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_TICK, '0, '0, 1'b0, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_RISE, 32'd4000, 23'd1000000, 1'b1, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_TICK, '0, '0, 1'b0, '0), 1'b0, '0});
    // widest possible pulse
    drill.push_back('{mk_ev(MODE_RISE, '0, '0, 1'b0, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_FALL, 32'hFFFF_FFFF, '0, 1'b0, '0), 1'b0, '0});
    drill.push_back('{mk_ev(MODE_POLL, '0, '0, 1'b0, '0), 1'b0, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    pick_idle(0);
    foreach (drill[i]) offer_event(drill[i].ev, drill[i].typed, drill[i].want);

    // short period so the errors cross both thresholds
    program_regs(10'd50, 23'd5000, 23'd2500, 23'd250, 23'd5, 8'd5, 17'd60);
    pick_idle(0);
    run_traffic(100);

    // everything early, corrections saturate high
    program_regs(10'd1023, PERIOD_MAX, 23'd0, PERIOD_MAX, 23'd0, 8'd255, 17'd131071);
    pick_idle(1);
    run_traffic(60);

    // everything late, corrections saturate at zero
    program_regs(10'd0, 23'd1, PERIOD_MAX, 23'd0, 23'd0, 8'd0, 17'd1);
    pick_idle(2);
    run_traffic(60);

    program_regs(10'($urandom), 23'd20000, 23'd10000, 23'd1000, PERIOD_MAX, 8'd3, 17'd0);
    pick_idle(3);
    run_traffic(60);

    // unsync count must stick at its ceiling, else the last tick would not correct
    program_regs(10'd10, 23'd1000, 23'd500, 23'd0, 23'd0, 8'd255, 17'd100);
    pick_idle(0);
    hold_req <= 1'b1;
    offer_event(mk_ev(MODE_RISE, $urandom, 23'd200, 1'b1, 17'($urandom)));
    repeat (SAT_TICKS) offer_event(noisy_ev(MODE_TICK));
    offer_event(mk_ev(MODE_RISE, $urandom, 23'd300, 1'b1, 17'($urandom)));
    offer_event(noisy_ev(MODE_TICK));

    for (int k = 0; k < 2; k++) begin
      nominal = 23'($urandom_range(20000, 1));
      unsync = 23'($urandom_range(nominal / 4));
      program_regs(10'($urandom), nominal, 23'($urandom_range(nominal)), unsync,
                   23'($urandom_range(unsync)), 8'($urandom_range(8)),
                   17'($urandom_range(200, 1)));
      pick_idle(k + 2);
      run_traffic(40);
    end

    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
